@@ rtl/core/multichannel_fir_dc_removal_defines.svh @@
// Assertion macros used by the checker of the FIR block.
`ifndef MULTICHANNEL_FIR_DC_REMOVAL_DEFINES_SVH
`define MULTICHANNEL_FIR_DC_REMOVAL_DEFINES_SVH

// Same-cycle implication, masked while reset is asserted.
`define MFDR_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mfdr check failed");

// Next-cycle implication, masked while reset is asserted.
`define MFDR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mfdr check failed");

// Next-cycle implication that also holds through reset.
`define MFDR_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("mfdr check failed");

`endif

@@ rtl/core/mfdr_pkg.sv @@
// Shared constants and controller/datapath interface types for the FIR block.
package mfdr_pkg;

    localparam int DEF_CHANNELS = 16;
    localparam int DEF_MAX_TAPS = 64;

    localparam int WORD_BITS   = 16;   // raw ADC word
    localparam int VAL_W       = 17;   // offset-corrected sample
    localparam int COEF_W      = 16;   // Q1.15 coefficient
    localparam int ACC_W       = 40;   // exact accumulator
    localparam int CH_FIELD_W  = 4;
    localparam int COEF_IDX_W  = 6;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int TAPS_CFG_W = 7;
    localparam int BITS_CFG_W = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_TAP_COUNT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_BITS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DC_LEVEL    = 2'd2;

    localparam logic [TAPS_CFG_W-1:0] TAP_COUNT_RST   = 7'd1;
    localparam logic [BITS_CFG_W-1:0] SAMPLE_BITS_RST = 5'd16;

    // controller -> datapath
    typedef struct packed {
        logic clear_step;   // clear one history/coefficient entry
        logic take;         // request accepted this cycle
        logic write;        // store new sample, set up tap walk
        logic issue;        // read one tap pair
        logic emit;         // load output register
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic clear_done;
        logic in_is_sample; // request is a sample on a built channel
        logic last_tap;
        logic pipe_busy;
        logic out_free;
    } t_dp_sts;

endpackage

@@ rtl/core/mfdr_ctrl.sv @@
// Sequencer for the FIR block: clearing pass, request intake, tap walk, drain.
module mfdr_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  mfdr_pkg::t_dp_sts i_sts,
    output mfdr_pkg::t_dp_cmd o_cmd
);
    import mfdr_pkg::*;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_WRITE = 3'd2;
    localparam logic [2:0] S_RUN   = 3'd3;
    localparam logic [2:0] S_DRAIN = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = (r_state == S_IDLE);
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear_step = 1'b1;
                if (i_sts.clear_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.take = 1'b1;
                    if (i_sts.in_is_sample) begin
                        n_state = S_WRITE;
                    end
                end
            end
            S_WRITE: begin
                o_cmd.write = 1'b1;
                n_state     = S_RUN;
            end
            S_RUN: begin
                o_cmd.issue = 1'b1;
                if (i_sts.last_tap) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!i_sts.pipe_busy && i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

endmodule

@@ rtl/core/mfdr_datapath.sv @@
// Datapath: config registers, history and coefficient memories, MAC, output register.
module mfdr_datapath #(
    parameter int CHANNELS = mfdr_pkg::DEF_CHANNELS,
    parameter int MAX_TAPS = mfdr_pkg::DEF_MAX_TAPS
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  mfdr_pkg::t_dp_cmd                      i_cmd,
    output mfdr_pkg::t_dp_sts                      o_sts,
    input  logic                                   i_cfg_we,
    input  logic        [mfdr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic        [mfdr_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                                   i_kind,
    input  logic        [mfdr_pkg::CH_FIELD_W-1:0] i_channel,
    input  logic        [mfdr_pkg::WORD_BITS-1:0]  i_raw_sample,
    input  logic        [mfdr_pkg::COEF_IDX_W-1:0] i_coef_index,
    input  logic signed [mfdr_pkg::COEF_W-1:0]     i_coef_value,
    input  logic                                   i_out_ready,
    output logic                                   o_out_valid,
    output logic        [mfdr_pkg::CH_FIELD_W-1:0] o_out_channel,
    output logic signed [mfdr_pkg::ACC_W-1:0]      o_filtered
);
    import mfdr_pkg::*;

    localparam int TAP_W  = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int CNT_W  = $clog2(MAX_TAPS + 1);
    localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int DEPTH  = CHANNELS * MAX_TAPS;
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SW     = TAP_W + 2;
    localparam int PROD_W = COEF_W + VAL_W;

    // ---------------- configuration ----------------
    logic [TAPS_CFG_W-1:0] r_tap_count;
    logic [BITS_CFG_W-1:0] r_sample_bits;
    logic [WORD_BITS-1:0]  r_dc_level;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap_count   <= TAP_COUNT_RST;
            r_sample_bits <= SAMPLE_BITS_RST;
            r_dc_level    <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_TAP_COUNT:   r_tap_count   <= i_cfg_wdata[TAPS_CFG_W-1:0];
                CFG_SAMPLE_BITS: r_sample_bits <= i_cfg_wdata[BITS_CFG_W-1:0];
                CFG_DC_LEVEL:    r_dc_level    <= i_cfg_wdata[WORD_BITS-1:0];
                default: ;
            endcase
        end
    end

    logic [CNT_W-1:0]      eff_taps;
    logic [BITS_CFG_W-1:0] eff_bits;
    logic [3:0]            shift_amt;

    always_comb begin
        priority if (r_tap_count == '0) begin
            eff_taps = CNT_W'(1);
        end else if (32'(r_tap_count) > MAX_TAPS) begin
            eff_taps = CNT_W'(MAX_TAPS);
        end else begin
            eff_taps = CNT_W'(r_tap_count);
        end
        priority if (r_sample_bits == '0) begin
            eff_bits = BITS_CFG_W'(1);
        end else if (32'(r_sample_bits) > WORD_BITS) begin
            eff_bits = BITS_CFG_W'(WORD_BITS);
        end else begin
            eff_bits = r_sample_bits;
        end
        shift_amt = 4'(BITS_CFG_W'(WORD_BITS) - eff_bits);
    end

    // ---------------- sample conditioning ----------------
    logic        [WORD_BITS-1:0] raw_sh;
    logic        [WORD_BITS-1:0] dc_sh;
    logic signed [VAL_W-1:0]     in_val;
    logic        [CH_W-1:0]      in_ch;
    logic                        ch_ok;

    assign raw_sh = i_raw_sample >> shift_amt;
    assign dc_sh  = r_dc_level >> shift_amt;
    assign in_val = signed'({1'b0, raw_sh}) - signed'({1'b0, dc_sh});
    assign in_ch  = CH_W'(i_channel);
    assign ch_ok  = (32'(i_channel) < CHANNELS);

    // ---------------- per-channel write pointers ----------------
    logic [TAP_W-1:0] r_hist_pos [CHANNELS];

    logic [CH_FIELD_W-1:0] r_ch;
    logic signed [VAL_W-1:0] r_val;
    logic [TAP_W-1:0]      r_pos;
    logic [AW-1:0]         r_base;
    logic [TAP_W-1:0]      r_slot;
    logic [TAP_W-1:0]      r_k;

    logic [TAP_W-1:0] pos_inc;
    logic [TAP_W-1:0] slot_inc;
    logic [SW-1:0]    start_sum;
    logic [TAP_W-1:0] start_slot;

    assign pos_inc   = (r_pos == TAP_W'(MAX_TAPS - 1)) ? '0 : r_pos + 1'b1;
    assign slot_inc  = (r_slot == TAP_W'(MAX_TAPS - 1)) ? '0 : r_slot + 1'b1;
    // oldest sample of the window: pos - (taps - 1), modulo the line length
    assign start_sum = SW'(r_pos) + SW'(MAX_TAPS) - SW'(eff_taps - 1'b1);
    assign start_slot = (start_sum >= SW'(MAX_TAPS)) ? TAP_W'(start_sum - SW'(MAX_TAPS))
                                                     : TAP_W'(start_sum);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < CHANNELS; c++) begin
                r_hist_pos[c] <= '0;
            end
        end else if (i_cmd.write) begin
            r_hist_pos[CH_W'(r_ch)] <= pos_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take && !i_kind && ch_ok) begin
            r_ch   <= i_channel;
            r_val  <= in_val;
            r_pos  <= r_hist_pos[in_ch];
            r_base <= AW'(in_ch * MAX_TAPS);
        end
        if (i_cmd.write) begin
            r_slot <= start_slot;
            r_k    <= '0;
        end else if (i_cmd.issue) begin
            r_slot <= slot_inc;
            r_k    <= r_k + 1'b1;
        end
    end

    // ---------------- clearing pass ----------------
    logic [AW-1:0] r_clr_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clear_step) begin
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    // ---------------- memories ----------------
    logic signed [COEF_W-1:0] r_coef_mem [MAX_TAPS];
    logic signed [VAL_W-1:0]  r_hist_mem [DEPTH];
    logic signed [COEF_W-1:0] r_coef_q;
    logic signed [VAL_W-1:0]  r_hist_q;
    logic [AW-1:0]            wr_addr;
    logic [AW-1:0]            rd_addr;

    assign wr_addr = r_base + AW'(r_pos);
    assign rd_addr = r_base + AW'(r_slot);

    always_ff @(posedge i_clk) begin
        if (i_cmd.clear_step && (32'(r_clr_addr) < MAX_TAPS)) begin
            r_coef_mem[TAP_W'(r_clr_addr)] <= '0;
        end else if (i_cmd.take && i_kind && (32'(i_coef_index) < MAX_TAPS)) begin
            r_coef_mem[TAP_W'(i_coef_index)] <= i_coef_value;
        end
        r_coef_q <= r_coef_mem[r_k];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clear_step) begin
            r_hist_mem[r_clr_addr] <= '0;
        end else if (i_cmd.write) begin
            r_hist_mem[wr_addr] <= r_val;
        end
        r_hist_q <= r_hist_mem[rd_addr];
    end

    // ---------------- multiply-accumulate ----------------
    logic                      r_rd_v;
    logic                      r_prod_v;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [ACC_W-1:0]   r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_v   <= 1'b0;
            r_prod_v <= 1'b0;
        end else begin
            r_rd_v   <= i_cmd.issue;
            r_prod_v <= r_rd_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= r_coef_q * r_hist_q;
        if (i_cmd.write) begin
            r_acc <= '0;
        end else if (r_prod_v) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
    end

    // ---------------- output register ----------------
    logic                           r_out_v;
    logic        [CH_FIELD_W-1:0]   r_out_ch;
    logic signed [ACC_W-1:0]        r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_v <= 1'b1;
        end else if (i_out_ready) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_ch   <= r_ch;
            r_out_data <= r_acc;
        end
    end

    assign o_out_valid   = r_out_v;
    assign o_out_channel = r_out_ch;
    assign o_filtered    = r_out_data;

    // ---------------- status ----------------
    assign o_sts.clear_done   = (r_clr_addr == AW'(DEPTH - 1));
    assign o_sts.in_is_sample = !i_kind && ch_ok;
    assign o_sts.last_tap     = (CNT_W'(r_k) == (eff_taps - 1'b1));
    assign o_sts.pipe_busy    = r_rd_v | r_prod_v;
    assign o_sts.out_free     = !r_out_v | i_out_ready;

endmodule

@@ rtl/core/multichannel_fir_dc_removal.sv @@
// Top level of the multichannel FIR filter with DC removal.
//
//   channel  direction  handshake                   carries
//   in       request    i_in_valid / o_in_ready     kind, channel, raw_sample, coef_index/value
//   out      result     o_out_valid / i_out_ready   out_channel, filtered
//   cfg      write      i_cfg_we (no wait)          tap_count, sample_bits, dc level
//
// A sample request occupies the block from intake to the end of its drain (tap_count clamped
// to 1..MAX_TAPS): one shared 16x17 multiply-accumulate takes one tap per cycle,
// after the intake and a history write, and then the read, multiply and accumulate
// registers drain. A coefficient load or a sample on an unbuilt channel is taken
// without leaving the idle state.
// After reset a clearing pass over all CHANNELS*MAX_TAPS entries zeroes the history and
// coefficient memories; o_in_ready stays low meanwhile, config writes still land.
// The result sits in an output register, so a stalled consumer only holds the
// block once the next result is ready to be loaded.
module multichannel_fir_dc_removal #(
    parameter int CHANNELS = mfdr_pkg::DEF_CHANNELS,   // 1..16
    parameter int MAX_TAPS = mfdr_pkg::DEF_MAX_TAPS    // 1..64
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // request channel
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  logic                                   i_kind,
    input  logic        [mfdr_pkg::CH_FIELD_W-1:0] i_channel,
    input  logic        [mfdr_pkg::WORD_BITS-1:0]  i_raw_sample,
    input  logic        [mfdr_pkg::COEF_IDX_W-1:0] i_coef_index,
    input  logic signed [mfdr_pkg::COEF_W-1:0]     i_coef_value,
    // result channel
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic        [mfdr_pkg::CH_FIELD_W-1:0] o_out_channel,
    output logic signed [mfdr_pkg::ACC_W-1:0]      o_filtered,
    // configuration
    input  logic                                   i_cfg_we,
    input  logic        [mfdr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic        [mfdr_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);
    import mfdr_pkg::*;

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    // sequencer: owns the state, drives one command set per cycle
    mfdr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (dp_sts),
        .o_cmd      (dp_cmd)
    );

    // storage, MAC and output register
    mfdr_datapath #(
        .CHANNELS (CHANNELS),
        .MAX_TAPS (MAX_TAPS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (dp_cmd),
        .o_sts         (dp_sts),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_kind        (i_kind),
        .i_channel     (i_channel),
        .i_raw_sample  (i_raw_sample),
        .i_coef_index  (i_coef_index),
        .i_coef_value  (i_coef_value),
        .i_out_ready   (i_out_ready),
        .o_out_valid   (o_out_valid),
        .o_out_channel (o_out_channel),
        .o_filtered    (o_filtered)
    );

endmodule

@@ rtl/core/mfdr_checker.sv @@
// Port-level checks for the FIR block, bound to the top level.
`include "multichannel_fir_dc_removal_defines.svh"

module mfdr_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input logic               i_kind,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input logic [3:0]         o_out_channel,
    input logic signed [39:0] o_filtered
);

    // result held until taken
    `MFDR_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid)

    // stalled result keeps its payload
    `MFDR_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, o_out_valid && !i_out_ready, $stable(o_filtered) && $stable(o_out_channel))

    // reset leaves no result pending and starts the clearing pass
    `MFDR_ASSERT_NEXT_ALWAYS(a_reset_quiet, i_clk, !i_rst_n, !o_out_valid && !o_in_ready)

    // a coefficient load never occupies the block
    `MFDR_ASSERT_NEXT(a_coef_one_cycle, i_clk, i_rst_n, i_in_valid && o_in_ready && i_kind, o_in_ready)

    // a new result only appears at the end of a sample's tap walk
    `MFDR_ASSERT_IMPL(a_result_from_walk, i_clk, i_rst_n, $rose(o_out_valid), !$past(o_in_ready))

endmodule

bind multichannel_fir_dc_removal mfdr_checker u_mfdr_checker (.*);
